[src/skmvt_pkg.sv]
// skmvt_pkg: shared constants, codes and structs for the sorted key table
// used by skmvt_cell and sorted_key_multivalue_table_top
`default_nettype none

package skmvt_pkg;

    localparam int MAX_KEYS      = 32;
    localparam int MAX_VALUES    = 16;
    localparam int PAGE_BYTES    = 512;
    localparam int PAGE_OVERHEAD = 7;
    localparam int KEY_BYTES     = 10;
    localparam int VALUE_BYTES   = 4;

    localparam int CNT_W   = $clog2(MAX_VALUES + 1);
    localparam int IDX_W   = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int KCNT_W  = $clog2(MAX_KEYS + 1);
    localparam int BYTES_W = $clog2(PAGE_BYTES + KEY_BYTES + VALUE_BYTES + 1);

    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_FIND    = 2'd1,
        MODE_DEL_KEY = 2'd2,
        MODE_DEL_VAL = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_KEY     = 3'd1,
        ST_NO_VALUE   = 3'd2,
        ST_LIST_FULL  = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_PAGE_FULL  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_INS_KEY = 3'd1,
        CMD_ADD_VAL = 3'd2,
        CMD_DEL_KEY = 3'd3,
        CMD_DEL_VAL = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] key;
        logic signed [31:0] value;
        logic [4:0]         max_ret;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] found_value;
        logic [4:0]         returned_count;
        logic               last;
    } t_out;

    typedef logic [MAX_VALUES-1:0][31:0] t_vals;

    // contents of one slot as handed between neighbouring cells
    typedef struct packed {
        logic               used;
        logic signed [31:0] key;
        logic [CNT_W-1:0]   cnt;
        t_vals              vals;
    } t_slot;

    typedef struct packed {
        logic             cap;
        t_cmd             cmd;
        logic [IDX_W-1:0] rd_idx;
    } t_ctl;

    typedef struct packed {
        logic             hit;
        logic             vfound;
        logic [CNT_W-1:0] cnt;
    } t_flags;

endpackage

`default_nettype wire

[src/skmvt_cell.sv]
// skmvt_cell: one key slot with its value list, compare flags and shift logic
// depends on skmvt_pkg
`default_nettype none

module skmvt_cell
    import skmvt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_in    i_req,
    input  wire t_ctl   i_ctl,
    input  wire t_slot  i_prev,
    input  wire logic   i_prev_ins,
    input  wire t_slot  i_next,
    output t_slot       o_slot,
    output logic        o_ins,
    output t_flags      o_flags,
    output logic [31:0] o_rd_val
);

    logic               r_used;
    logic signed [31:0] r_key;
    logic [CNT_W-1:0]   r_cnt;
    t_vals              r_vals;

    logic                  r_hit;
    logic                  r_gt;
    logic                  r_ge;
    logic [MAX_VALUES-1:0] r_vhit;
    logic [MAX_VALUES-1:0] w_from;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_hit <= r_used && (r_key == i_req.key);
            r_gt  <= r_used && (r_key > i_req.key);
            r_ge  <= r_used && (r_key >= i_req.key);
            for (int j = 0; j < MAX_VALUES; j++) begin
                r_vhit[j] <= (CNT_W'(j) < r_cnt) && (r_vals[j] == i_req.value);
            end
        end
    end

    // positions at or above the matching value move down by one
    always_comb begin
        for (int j = 0; j < MAX_VALUES; j++) begin
            w_from[j] = |(r_vhit << (MAX_VALUES - 1 - j));
        end
    end

    assign o_ins = r_gt || !r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            case (i_ctl.cmd)
                CMD_INS_KEY: begin
                    if (o_ins) begin
                        if (i_prev_ins) begin
                            r_used <= i_prev.used;
                            r_key  <= i_prev.key;
                            r_cnt  <= i_prev.cnt;
                            r_vals <= i_prev.vals;
                        end else begin
                            r_used    <= 1'b1;
                            r_key     <= i_req.key;
                            r_cnt     <= CNT_W'(1);
                            r_vals[0] <= i_req.value;
                        end
                    end
                end
                CMD_ADD_VAL: begin
                    if (r_hit) begin
                        r_vals[r_cnt[IDX_W-1:0]] <= i_req.value;
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                CMD_DEL_KEY: begin
                    if (r_ge) begin
                        r_used <= i_next.used;
                        r_key  <= i_next.key;
                        r_cnt  <= i_next.cnt;
                        r_vals <= i_next.vals;
                    end
                end
                CMD_DEL_VAL: begin
                    if (r_hit) begin
                        for (int j = 0; j < MAX_VALUES - 1; j++) begin
                            if (w_from[j]) begin
                                r_vals[j] <= r_vals[j+1];
                            end
                        end
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_slot.used = r_used;
    assign o_slot.key  = r_key;
    assign o_slot.cnt  = r_cnt;
    assign o_slot.vals = r_vals;

    assign o_flags.hit    = r_hit;
    assign o_flags.vfound = r_hit && (|r_vhit);
    assign o_flags.cnt    = r_hit ? r_cnt : '0;

    assign o_rd_val = r_hit ? r_vals[i_ctl.rd_idx] : 32'd0;

endmodule

`default_nettype wire

[src/sorted_key_multivalue_table_top.sv]
// sorted_key_multivalue_table_top: sequencer, budget counters and the row of
// key cells; depends on skmvt_pkg and skmvt_cell
//
// Usage: one input channel (i_in_valid / o_in_ready / i_in_data) takes a
// request: insert pair, find key, delete key or delete one value. One output
// channel (o_out_valid / i_out_ready / o_out_data) returns the results.
// Keys sit sorted in a row of cells, one key and its value list per cell;
// inserts and deletes shift the row by one cell, all cells at once.
// The first result is registered once the states S_CMP (capture compares),
// S_DEC (decide) and S_EXE (apply and present) have followed the input
// transfer. Every request gives one result, except a find that returns n
// values, which gives n results, one a cycle while the output is ready.
// The input is taken only when the previous request is fully delivered.
// A stall on the output holds the current result and the whole sequencer.
// Reset empties the table (no keys, 7 bytes of page budget used); the value
// storage itself is not cleared and needs no clearing pass.
`default_nettype none

module sorted_key_multivalue_table_top
    import skmvt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_DEC  = 5'b00100,
        S_EXE  = 5'b01000,
        S_OUT  = 5'b10000
    } t_fsm;

    t_fsm               r_state;
    t_in                r_req;
    logic [KCNT_W-1:0]  r_keys;
    logic [BYTES_W-1:0] r_bytes;
    t_cmd               r_cmd;
    t_status            r_status;
    logic               r_find;
    logic [CNT_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_idx;
    t_out               r_out;
    logic               r_out_valid;

    t_ctl   w_ctl;
    t_slot  w_slot  [MAX_KEYS];
    logic   w_ins   [MAX_KEYS];
    t_flags w_flags [MAX_KEYS];
    logic [31:0] w_rd [MAX_KEYS];
    t_slot  w_empty;

    logic             w_hit;
    logic             w_vfound;
    logic [CNT_W-1:0] w_cnt;
    logic [31:0]      w_val;

    assign w_empty = '0;

    assign w_ctl.cap    = (r_state == S_CMP);
    assign w_ctl.cmd    = (r_state == S_EXE) ? r_cmd : CMD_NONE;
    assign w_ctl.rd_idx = r_idx[IDX_W-1:0];

    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        skmvt_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_req      (r_req),
            .i_ctl      (w_ctl),
            .i_prev     ((g == 0) ? w_empty : w_slot[(g == 0) ? 0 : g-1]),
            .i_prev_ins ((g == 0) ? 1'b0 : w_ins[(g == 0) ? 0 : g-1]),
            .i_next     ((g == MAX_KEYS-1) ? w_empty :
                         w_slot[(g == MAX_KEYS-1) ? g : g+1]),
            .o_slot     (w_slot[g]),
            .o_ins      (w_ins[g]),
            .o_flags    (w_flags[g]),
            .o_rd_val   (w_rd[g])
        );
    end

    // at most one cell matches, so the gated outputs can be or-ed together
    always_comb begin
        w_hit    = 1'b0;
        w_vfound = 1'b0;
        w_cnt    = '0;
        w_val    = '0;
        for (int i = 0; i < MAX_KEYS; i++) begin
            w_hit    = w_hit | w_flags[i].hit;
            w_vfound = w_vfound | w_flags[i].vfound;
            w_cnt    = w_cnt | w_flags[i].cnt;
            w_val    = w_val | w_rd[i];
        end
    end

    logic [5:0] w_cnt_x;
    logic [5:0] w_max_x;
    assign w_cnt_x = 6'(w_cnt);
    assign w_max_x = 6'(r_req.max_ret);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_keys      <= '0;
            r_bytes     <= BYTES_W'(PAGE_OVERHEAD);
            r_out_valid <= 1'b0;
            r_cmd       <= CMD_NONE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_cmd    <= CMD_NONE;
                    r_status <= ST_OK;
                    r_find   <= 1'b0;
                    r_idx    <= '0;
                    r_total  <= '0;
                    case (r_req.mode)
                        MODE_INSERT: begin
                            if (w_hit) begin
                                if (w_vfound) begin
                                    r_status <= ST_OK;
                                end else if (w_cnt == CNT_W'(MAX_VALUES)) begin
                                    r_status <= ST_LIST_FULL;
                                end else if (r_bytes + BYTES_W'(VALUE_BYTES) >
                                             BYTES_W'(PAGE_BYTES)) begin
                                    r_status <= ST_PAGE_FULL;
                                end else begin
                                    r_cmd   <= CMD_ADD_VAL;
                                    r_bytes <= r_bytes + BYTES_W'(VALUE_BYTES);
                                end
                            end else if (r_keys == KCNT_W'(MAX_KEYS)) begin
                                r_status <= ST_TABLE_FULL;
                            end else if (r_bytes + BYTES_W'(KEY_BYTES + VALUE_BYTES) >
                                         BYTES_W'(PAGE_BYTES)) begin
                                r_status <= ST_PAGE_FULL;
                            end else begin
                                r_cmd   <= CMD_INS_KEY;
                                r_keys  <= r_keys + KCNT_W'(1);
                                r_bytes <= r_bytes + BYTES_W'(KEY_BYTES + VALUE_BYTES);
                            end
                        end
                        MODE_FIND: begin
                            if (!w_hit) begin
                                r_status <= ST_NO_KEY;
                            end else begin
                                r_find  <= 1'b1;
                                r_total <= (w_cnt_x > w_max_x) ? CNT_W'(r_req.max_ret)
                                                               : w_cnt;
                            end
                        end
                        MODE_DEL_KEY: begin
                            if (!w_hit) begin
                                r_status <= ST_NO_KEY;
                            end else begin
                                r_cmd   <= CMD_DEL_KEY;
                                r_keys  <= r_keys - KCNT_W'(1);
                                r_bytes <= r_bytes - BYTES_W'(KEY_BYTES)
                                           - BYTES_W'(w_cnt) * BYTES_W'(VALUE_BYTES);
                            end
                        end
                        default: begin
                            if (!w_hit) begin
                                r_status <= ST_NO_KEY;
                            end else if (!w_vfound) begin
                                r_status <= ST_NO_VALUE;
                            end else if (w_cnt == CNT_W'(1)) begin
                                // last value gone, so the key goes too
                                r_cmd   <= CMD_DEL_KEY;
                                r_keys  <= r_keys - KCNT_W'(1);
                                r_bytes <= r_bytes - BYTES_W'(KEY_BYTES + VALUE_BYTES);
                            end else begin
                                r_cmd   <= CMD_DEL_VAL;
                                r_bytes <= r_bytes - BYTES_W'(VALUE_BYTES);
                            end
                        end
                    endcase
                    r_state <= S_EXE;
                end
                S_EXE: begin
                    r_out_valid <= 1'b1;
                    if (r_find && (r_total != '0)) begin
                        r_out.status         <= ST_OK;
                        r_out.found_value    <= w_val;
                        r_out.returned_count <= 5'(r_total);
                        r_out.last           <= (r_total == CNT_W'(1));
                        r_idx                <= CNT_W'(1);
                    end else begin
                        r_out.status         <= r_status;
                        r_out.found_value    <= '0;
                        r_out.returned_count <= '0;
                        r_out.last           <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        if (r_out.last) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_out.found_value <= w_val;
                            r_out.last        <= (r_idx + CNT_W'(1) == r_total);
                            r_idx             <= r_idx + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_OUT))
        else $error("result shown outside the output state");

    a_keys_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_keys <= KCNT_W'(MAX_KEYS))
        else $error("key count beyond table size");

    a_bytes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes >= BYTES_W'(PAGE_OVERHEAD)) && (r_bytes <= BYTES_W'(PAGE_BYTES)))
        else $error("page budget out of range");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && r_out.last) |=> (r_state == S_IDLE))
        else $error("final transfer did not end the request");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CMP))
        else $error("accepted request not started");

endmodule

`default_nettype wire
